FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked at every rising clk edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dbht_pkg.sv
// ----------------------------------------------------------------------------
// dbht_pkg
// Types and constants for the dual button hold timeout block.
// ----------------------------------------------------------------------------
package dbht_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int HOLD_W        = 19;
    localparam int CFG_IDX_W     = 3;
    localparam int NUM_CHAN      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CH1_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CH1_DETECT_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CH1_HOLD_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CH2_ENABLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CH2_DETECT_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CH2_HOLD_MS    = 3'd5;

    // Last reported state of a channel or of the combined OR
    typedef enum logic [1:0] {
        REP_OFF     = 2'd0,
        REP_ON      = 2'd1,
        REP_UNKNOWN = 2'd2
    } rep_t;

    // One result word
    typedef struct packed {
        logic chan1_changed;
        logic chan1_on;
        logic chan2_changed;
        logic chan2_on;
        logic any_changed;
        logic any_on;
    } result_t;

endpackage

FILE: rtl/core/dual_button_hold_timeout.sv
// ----------------------------------------------------------------------------
// dual_button_hold_timeout
// Two-channel retriggerable hold timer for push buttons, change reporting.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one poll word per accept, carrying
//    pin1_level, pin2_level and the free-running millisecond time now_ms.
//  - Output channel (out_valid / out_stall): one result word per poll whose
//    channel state or combined OR state differs from the last report; polls
//    with no change produce nothing.
//  - Config channel (cfg_valid / cfg_ready): cfg_index selects enable,
//    detect polarity and hold time of each channel; cfg_ready is always high.
//    Write only while the block is idle.
//  - Each result word is registered, in the skid register when stalled.
//  - Throughput: one poll per cycle unless stalled; all per-poll work (time
//    subtract, hold compare, state update) is one combinational pass.
//  - Stall: a two-entry output (result register plus skid register) lets the
//    block take a poll while a result waits; in_stall rises only when the
//    skid register is occupied.
//  - Reset: configuration clears to zero (both channels disabled), detection
//    times clear to zero, reported states become unknown so the first poll
//    always reports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_button_hold_timeout
    import dbht_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HOLD_W-1:0]    cfg_data,
    // poll words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 pin1_level,
    input  logic                 pin2_level,
    input  logic [NOW_W-1:0]     now_ms,
    // result words
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 chan1_changed,
    output logic                 chan1_on,
    output logic                 chan2_changed,
    output logic                 chan2_on,
    output logic                 any_changed,
    output logic                 any_on
);

    // Compare width covers both elapsed time and hold time
    localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NUM_CHAN-1:0] en_reg;
    logic [NUM_CHAN-1:0] low_reg;
    logic [HOLD_W-1:0]   hold_reg [NUM_CHAN];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg      <= '0;
            low_reg     <= '0;
            hold_reg[0] <= '0;
            hold_reg[1] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CH1_ENABLE:     en_reg[0]   <= cfg_data[0];
                CFG_CH1_DETECT_LOW: low_reg[0]  <= cfg_data[0];
                CFG_CH1_HOLD_MS:    hold_reg[0] <= cfg_data;
                CFG_CH2_ENABLE:     en_reg[1]   <= cfg_data[0];
                CFG_CH2_DETECT_LOW: low_reg[1]  <= cfg_data[0];
                CFG_CH2_HOLD_MS:    hold_reg[1] <= cfg_data;
                default:            ;   // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Channel state and per-poll evaluation
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] last_reg  [NUM_CHAN];
    logic [TIME_BITS-1:0] last_next [NUM_CHAN];
    rep_t                 rep_reg   [NUM_CHAN];
    rep_t                 rep_next  [NUM_CHAN];
    rep_t                 comb_reg;
    rep_t                 comb_next;

    logic [TIME_BITS-1:0] now_t;
    logic [NUM_CHAN-1:0]  pin;
    logic [NUM_CHAN-1:0]  chg;
    logic [NUM_CHAN-1:0]  on;
    logic                 any_state;
    logic                 any_chg;
    logic                 accept;
    result_t              res;
    logic                 res_any;

    assign now_t  = TIME_BITS'(now_ms);   // modulo 2^TIME_BITS
    assign pin    = {pin2_level, pin1_level};
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        logic                 det;
        logic [TIME_BITS-1:0] since;
        logic                 val;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            det          = (pin[i] == !low_reg[i]);
            since        = '0;
            val          = 1'b0;
            last_next[i] = last_reg[i];
            rep_next[i]  = rep_reg[i];
            chg[i]       = 1'b0;
            if (en_reg[i])
            begin
                if (det)
                begin
                    last_next[i] = now_t;
                end
                // wrap-safe elapsed time since last detection
                since = now_t - last_next[i];
                val   = det || (CMP_W'(since) < CMP_W'(hold_reg[i]));
                if (rep_reg[i] != (val ? REP_ON : REP_OFF))
                begin
                    chg[i]      = 1'b1;
                    rep_next[i] = val ? REP_ON : REP_OFF;
                end
            end
            on[i] = en_reg[i] && (rep_next[i] == REP_ON);
        end
        any_state = |on;
        any_chg   = (comb_reg != (any_state ? REP_ON : REP_OFF));
        comb_next = any_state ? REP_ON : REP_OFF;

        res.chan1_changed = chg[0];
        res.chan1_on      = on[0];
        res.chan2_changed = chg[1];
        res.chan2_on      = on[1];
        res.any_changed   = any_chg;
        res.any_on        = any_state;
        res_any           = chg[0] || chg[1] || any_chg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg[0] <= '0;
            last_reg[1] <= '0;
            rep_reg[0]  <= REP_UNKNOWN;
            rep_reg[1]  <= REP_UNKNOWN;
            comb_reg    <= REP_UNKNOWN;
        end
        else if (accept)
        begin
            last_reg[0] <= last_next[0];
            last_reg[1] <= last_next[1];
            rep_reg[0]  <= rep_next[0];
            rep_reg[1]  <= rep_next[1];
            comb_reg    <= comb_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // skid drains first; input is stalled meanwhile
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept && res_any;
                out_next       = res;
            end
        end
        else if (accept && res_any)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_stall      = skid_valid_reg;
    assign out_valid     = out_valid_reg;
    assign chan1_changed = out_reg.chan1_changed;
    assign chan1_on      = out_reg.chan1_on;
    assign chan2_changed = out_reg.chan2_changed;
    assign chan2_on      = out_reg.chan2_on;
    assign any_changed   = out_reg.any_changed;
    assign any_on        = out_reg.any_on;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_skid_behind_out, skid_valid_reg |-> out_valid_reg,
        "skid holds a word while output register is empty")
    `ASSERT_NEXT(a_change_reported, accept && res_any, out_valid_reg,
        "changed poll did not produce a result word")
    `ASSERT_CLK(a_any_is_or, out_valid_reg |-> (out_reg.any_on ==
        (out_reg.chan1_on || out_reg.chan2_on)), "combined state is not OR of channels")

endmodule

FILE: tb/sv/dual_button_hold_timeout_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_button_hold_timeout_tb
// Self-checking bench for the two-channel button hold timer. Polls the block
// with pin levels and a wrapping millisecond time, tracks hold timers and
// last reports in a scoreboard and checks each result word field by field.
// ----------------------------------------------------------------------------
module dual_button_hold_timeout_tb
    import dbht_pkg::*;
();

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the hold timers and of the last
    // reported states, and a queue of the result words still to arrive.
    // ------------------------------------------------------------------------
    class hold_report_board;
        bit               enable[2];
        bit               detect_low[2];
        logic [HOLD_W-1:0] hold_ms[2];
        logic [NOW_W-1:0]  last_hit[2];
        rep_t             chan_rep[2];
        rep_t             any_rep;
        result_t          pending_reports[$];
        int               errors;

        function new();
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                enable[c]     = 1'b0;
                detect_low[c] = 1'b0;
                hold_ms[c]    = '0;
                last_hit[c]   = '0;
                chan_rep[c]   = REP_UNKNOWN;
            end
            any_rep = REP_UNKNOWN;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] data);
            case (idx)
                CFG_CH1_ENABLE:     enable[0]     = data[0];
                CFG_CH1_DETECT_LOW: detect_low[0] = data[0];
                CFG_CH1_HOLD_MS:    hold_ms[0]    = data;
                CFG_CH2_ENABLE:     enable[1]     = data[0];
                CFG_CH2_DETECT_LOW: detect_low[1] = data[0];
                CFG_CH2_HOLD_MS:    hold_ms[1]    = data;
                default: ;
            endcase
        endfunction

        // Retriggerable hold of one channel; 1 when its reported state moved.
        function bit poll_chan(int c, logic pin, logic [NOW_W-1:0] now);
            bit               hit;
            logic [NOW_W-1:0] elapsed;
            rep_t             state;
            hit = (pin == !detect_low[c]);
            if (!enable[c])
                return 1'b0;
            if (hit)
                last_hit[c] = now;
            elapsed = now - last_hit[c];
            state = (hit || elapsed < {{(NOW_W-HOLD_W){1'b0}}, hold_ms[c]}) ? REP_ON : REP_OFF;
            if (chan_rep[c] == state)
                return 1'b0;
            chan_rep[c] = state;
            return 1'b1;
        endfunction

        function void note_poll(logic pin1, logic pin2, logic [NOW_W-1:0] now);
            bit      c1;
            bit      c2;
            bit      on1;
            bit      on2;
            bit      anyc;
            rep_t    any_state;
            result_t word;
            c1  = poll_chan(0, pin1, now);
            c2  = poll_chan(1, pin2, now);
            on1 = enable[0] && chan_rep[0] == REP_ON;
            on2 = enable[1] && chan_rep[1] == REP_ON;
            any_state = (on1 || on2) ? REP_ON : REP_OFF;
            anyc = 1'b0;
            if (any_rep != any_state)
            begin
                any_rep = any_state;
                anyc    = 1'b1;
            end
            if (c1 || c2 || anyc)
            begin
                word.chan1_changed = c1;
                word.chan1_on      = on1;
                word.chan2_changed = c2;
                word.chan2_on      = on2;
                word.any_changed   = anyc;
                word.any_on        = on1 | on2;
                pending_reports.push_back(word);
            end
        endfunction

        function void check_report(result_t got);
            string   names[6];
            result_t want;
            names = '{"any_on", "any_changed", "chan2_on", "chan2_changed",
                      "chan1_on", "chan1_changed"};
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %b", $time, got);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            for (int i = 0; i < 6; i++)
            begin
                if (want[i] !== got[i])
                begin
                    $display("%0t: %s mismatch, expected %b, actual %b",
                             $time, names[i], want[i], got[i]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HOLD_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 pin1_level;
    logic                 pin2_level;
    logic [NOW_W-1:0]     now_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic                 chan1_changed;
    logic                 chan1_on;
    logic                 chan2_changed;
    logic                 chan2_on;
    logic                 any_changed;
    logic                 any_on;

    hold_report_board board = new();

    // Idling controls: gap_odds shapes input gaps (0 = none), quiet turns
    // off all idling for the tail of the run.
    int gap_odds   = 4;
    bit quiet      = 1'b0;

    dual_button_hold_timeout dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pin1_level    (pin1_level),
        .pin2_level    (pin2_level),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chan1_changed (chan1_changed),
        .chan1_on      (chan1_on),
        .chan2_changed (chan2_changed),
        .chan2_on      (chan2_on),
        .any_changed   (any_changed),
        .any_on        (any_on)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitors. All sample at the rising edge, before that edge's updates land,
    // so they see the values the block saw.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            board.write_reg(cfg_index, cfg_data);
    end

    // A poll word is taken: predict what it reports
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_poll(pin1_level, pin2_level, now_ms);
    end

    // A result word is taken: compare with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_report({chan1_changed, chan1_on, chan2_changed, chan2_on,
                                any_changed, any_on});
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure: random stall bursts, with the stall density
    // reshuffled now and then so some stretches have no stalls at all.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_odds;
        int burst;
        stall_odds = 2;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 255) == 0)
                stall_odds = $urandom_range(0, 3);
            if (!quiet && stall_odds != 0 && $urandom_range(0, 4 * stall_odds) == 0)
            begin
                burst = $urandom_range(1, 19);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one poll word and hold it until taken. in_valid stays high on
    // return; the caller lowers it at the end of a phase.
    task automatic send_poll(logic pin1, logic pin2, logic [NOW_W-1:0] now);
        int burst;
        if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            burst = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (burst) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pin1_level <= pin1;
        pin2_level <= pin2;
        now_ms     <= now;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop polling and wait until every predicted word has come out, then
    // wait on so that a poll that reports nothing has also passed.
    task automatic end_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all six registers back to back; block must be idle.
    task automatic program_regs(bit en1, bit dl1, logic [HOLD_W-1:0] h1,
                                bit en2, bit dl2, logic [HOLD_W-1:0] h2);
        logic [CFG_IDX_W-1:0] idx[6];
        logic [HOLD_W-1:0]    val[6];
        idx = '{CFG_CH1_ENABLE, CFG_CH1_DETECT_LOW, CFG_CH1_HOLD_MS,
                CFG_CH2_ENABLE, CFG_CH2_DETECT_LOW, CFG_CH2_HOLD_MS};
        val = '{{{(HOLD_W-1){1'b0}}, en1}, {{(HOLD_W-1){1'b0}}, dl1}, h1,
                {{(HOLD_W-1){1'b0}}, en2}, {{(HOLD_W-1){1'b0}}, dl2}, h2};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Hold time for a random phase: the extremes show up now and then,
    // mostly short holds so the channels toggle often.
    function automatic logic [HOLD_W-1:0] pick_hold();
        case ($urandom_range(0, 15))
            0, 1:    return '0;
            2:       return '1;
            3:       return HOLD_W'(300000);
            4, 5:    return HOLD_W'($urandom_range(1, 5000));
            default: return HOLD_W'($urandom_range(1, 64));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int               sent;
        int               count;
        int               step_max;
        bit               p1;
        bit               p2;
        bit               en1;
        bit               en2;
        logic [HOLD_W-1:0] h1;
        logic [HOLD_W-1:0] h2;
        logic [NOW_W-1:0]  t;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        pin1_level = 1'b0;
        pin2_level = 1'b0;
        now_ms     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: both channels off. First poll still reports,
        // the combined state going from unknown to off; the next is silent.
        send_poll(1'b0, 1'b0, 32'h0000_0000);
        send_poll(1'b1, 1'b1, 32'hFFFF_FFFF);
        end_phase();

        // Channel one detects high with a short hold, channel two detects low
        // with zero hold. Detection just before the time wraps, hold expiring
        // just after it.
        program_regs(1'b1, 1'b0, HOLD_W'(10), 1'b1, 1'b1, '0);
        send_poll(1'b1, 1'b1, 32'hFFFF_FFF8);
        send_poll(1'b0, 1'b1, 32'hFFFF_FFFE);
        send_poll(1'b0, 1'b0, 32'h0000_0001);
        send_poll(1'b0, 1'b0, 32'h0000_0002);
        send_poll(1'b0, 1'b1, 32'h0000_0003);
        send_poll(1'b1, 1'b0, 32'h0000_0004);
        send_poll(1'b0, 1'b1, 32'h0000_000D);
        send_poll(1'b0, 1'b1, 32'h0000_000E);
        end_phase();

        // Largest hold on both, polarities swapped, then huge time jumps
        program_regs(1'b1, 1'b1, '1, 1'b1, 1'b0, '1);
        send_poll(1'b0, 1'b1, 32'h8000_0000);
        send_poll(1'b1, 1'b0, 32'h8007_FFFE);
        send_poll(1'b1, 1'b0, 32'h8007_FFFF);
        send_poll(1'b1, 1'b1, 32'h0000_0000);
        send_poll(1'b1, 1'b0, 32'h0007_FFFF);
        end_phase();

        // Channel two disabled while channel one toggles; its state is frozen
        program_regs(1'b1, 1'b0, HOLD_W'(300000), 1'b0, 1'b0, HOLD_W'(5));
        send_poll(1'b1, 1'b1, 32'h1234_5678);
        send_poll(1'b0, 1'b1, 32'h1238_F0A7);
        send_poll(1'b0, 1'b0, 32'h1238_F0A8);
        send_poll(1'b0, 1'b1, 32'h5555_5555);
        end_phase();

        // Random phases: fresh configuration each time, time moving forward
        // in steps sized to the hold times, pins held for random stretches.
        sent = 0;
        t    = $urandom();
        p1   = 1'b0;
        p2   = 1'b0;
        while (sent < 1650)
        begin
            en1 = ($urandom_range(0, 4) != 0);
            en2 = ($urandom_range(0, 4) != 0);
            h1  = pick_hold();
            h2  = pick_hold();
            program_regs(en1, 1'($urandom_range(0, 1)), h1,
                         en2, 1'($urandom_range(0, 1)), h2);
            step_max = (h1 > h2) ? int'(h1) : int'(h2);
            step_max = (step_max > 5000) ? step_max : 2 * step_max + 4;
            gap_odds = $urandom_range(0, 3) * 3;
            if ($urandom_range(0, 7) == 0)
                t = 32'hFFFF_FFFF - $urandom_range(0, 3 * step_max);
            count = $urandom_range(30, 120);
            for (int i = 0; i < count && sent < 1650; i++)
            begin
                quiet = (sent >= 1380);
                if ($urandom_range(0, 2) == 0)
                    p1 = !p1;
                if ($urandom_range(0, 2) == 0)
                    p2 = !p2;
                if ($urandom_range(0, 31) == 0)
                    t = $urandom();
                else
                    t = t + $urandom_range(0, step_max);
                send_poll(p1, p2, t);
                sent++;
            end
            end_phase();
        end

        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("dual_button_hold_timeout_tb passed");
        else
            $display("dual_button_hold_timeout_tb failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("dual_button_hold_timeout_tb failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dbht_pkg.sv
rtl/core/dual_button_hold_timeout.sv
tb/sv/dual_button_hold_timeout_tb.sv
